FILE: rtl/cascaded_prescaled_timer_bank_macros.svh
// Assertion macros for the cascaded prescaled timer bank.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CASCADED_PRESCALED_TIMER_BANK_MACROS_SVH
`define CASCADED_PRESCALED_TIMER_BANK_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define CPTB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cptb: assertion failed");
// Condition must never be true outside reset.
`define CPTB_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cptb: forbidden condition seen");
`else
`define CPTB_ASSERT(lbl, clk, rst_n, prop)
`define CPTB_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/cptb_pkg.sv
// Package for the cascaded prescaled timer bank: op codes, control word layout,
// field widths and parameter defaults. No dependencies.
package cptb_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 4;
  localparam int unsigned CYCLE_BITS_DEF = 12;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned IRQ_W   = 4;
  localparam int unsigned RES_W   = 10;
  localparam int unsigned OUT_W   = ((DATA_W + IRQ_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_CTL    = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_RELOAD = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_CTL    = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_COUNT  = 3'd4;

  localparam int unsigned CTL_CASCADE_BIT = 2;
  localparam int unsigned CTL_IRQ_BIT     = 6;
  localparam int unsigned CTL_ENABLE_BIT  = 7;

  localparam logic [1:0] PSC_DIV1    = 2'd0;
  localparam logic [1:0] PSC_DIV64   = 2'd1;
  localparam logic [1:0] PSC_DIV256  = 2'd2;
  localparam logic [1:0] PSC_DIV1024 = 2'd3;

  // Prescaler select to right-shift amount.
  function automatic logic [3:0] psc_shift(input logic [1:0] sel);
    logic [3:0] sh;
    unique case (sel)
      PSC_DIV1:    sh = 4'd0;
      PSC_DIV64:   sh = 4'd6;
      PSC_DIV256:  sh = 4'd8;
      PSC_DIV1024: sh = 4'd10;
      default:     sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

FILE: rtl/cascaded_prescaled_timer_bank.sv
// Cascaded prescaled timer bank: 16-bit reload timers with prescaler and cascade.
// Depends on cptb_pkg and cascaded_prescaled_timer_bank_macros.svh.
//
//  channel  | signals                          | contents (low bit first)
//  ---------+----------------------------------+----------------------------------------
//  s_axis   | tvalid tready tdata tuser        | tuser: op; tdata: timer_index,
//           |                                  |   write_value, cycles
//  m_axis   | tvalid tready tdata              | tdata: read_data, irq_mask
//
// One request at a time. A register request passes through the REG and FIN states,
// its result is registered at the finish step, and the block returns to idle.
// A tick scans the timers one per cycle, stopping to advance each enabled timer that
// heads a chain; a timer whose count wraps runs a one-bit-per-cycle restoring divider
// (TW = max(CYCLE_BITS,10)+1 quotient bits, 13 by default) plus the ADV, DIVEND and
// CHAIN steps, once per timer reached along the cascade chain.
// Reset clears all timer state at once. The result waits in an output register
// while the next request is taken; a stalled result holds only the finish step.
`include "cascaded_prescaled_timer_bank_macros.svh"

module cascaded_prescaled_timer_bank
  import cptb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int unsigned CYCLE_BITS = CYCLE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // timer_index[1:0], write_value[17:2], cycles[CYCLE_BITS+17:18], zero pad
  input  logic [((IDX_W+DATA_W+CYCLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op[2:0]
  input  logic [OP_W-1:0]                              s_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // read_data[15:0], irq_mask[19:16], zero pad
  output logic [OUT_W-1:0]                             m_axis_tdata
);

  localparam int unsigned TW    = ((CYCLE_BITS > RES_W) ? CYCLE_BITS : RES_W) + 1;
  localparam int unsigned CMP_W = (TW > 17) ? TW : 17;
  localparam int unsigned IW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW    = $clog2(NUM_TIMERS + 1);
  localparam int unsigned BC_W  = $clog2(TW + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REG    = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_ADV    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DIVEND = 3'd5;
  localparam logic [2:0] ST_CHAIN  = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cur_q, cur_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic                  vld_q, vld_d;
  logic [DATA_W-1:0]     val_q, val_d;
  logic [CYCLE_BITS-1:0] cyc_q, cyc_d;
  logic [DATA_W-1:0]     rd_q, rd_d;
  logic [IRQ_W-1:0]      irq_q, irq_d;
  logic [TW-1:0]         n_q, n_d;
  logic [TW-1:0]         dvd_q, dvd_d;
  logic [16:0]           rem_q, rem_d;
  logic [16:0]           per_q, per_d;
  logic [BC_W-1:0]       bcnt_q, bcnt_d;
  logic                  m_valid_q, m_valid_d;
  logic [OUT_W-1:0]      m_data_q, m_data_d;

  logic [DATA_W-1:0] cnt_q [NUM_TIMERS];
  logic [DATA_W-1:0] rld_q [NUM_TIMERS];
  logic [DATA_W-1:0] ctl_q [NUM_TIMERS];
  logic [RES_W-1:0]  res_q [NUM_TIMERS];

  logic              cnt_we, rld_we, ctl_we, res_we;
  logic [DATA_W-1:0] cnt_wd, rld_wd, ctl_wd;
  logic [RES_W-1:0]  res_wd;

  logic [IW-1:0]     ix;
  logic              cur_ok;
  logic [DATA_W-1:0] cnt_rd, rld_rd, ctl_rd;
  logic [RES_W-1:0]  res_rd;
  logic [16:0]       wrap;
  logic [TW-1:0]     total;
  logic [3:0]        sh;
  logic [17:0]       rem_sh;
  logic              s_idx_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Shared read port: every timer array is looked up at the single cursor.
  assign ix     = cur_q[IW-1:0];
  assign cur_ok = (cur_q < CW'(NUM_TIMERS));
  assign cnt_rd = cur_ok ? cnt_q[ix] : '0;
  assign rld_rd = cur_ok ? rld_q[ix] : '0;
  assign ctl_rd = cur_ok ? ctl_q[ix] : '0;
  assign res_rd = cur_ok ? res_q[ix] : '0;

  assign wrap     = 17'h10000 - {1'b0, cnt_rd};
  assign total    = TW'(res_rd) + TW'(cyc_q);
  assign sh       = psc_shift(ctl_rd[1:0]);
  assign rem_sh   = {rem_q, dvd_q[TW-1]};
  assign s_idx_ok = (32'(s_axis_tdata[IDX_W-1:0]) < 32'(NUM_TIMERS));

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    op_d      = op_q;
    vld_d     = vld_q;
    val_d     = val_q;
    cyc_d     = cyc_q;
    rd_d      = rd_q;
    irq_d     = irq_q;
    n_d       = n_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    per_d     = per_q;
    bcnt_d    = bcnt_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    cnt_we    = 1'b0;
    rld_we    = 1'b0;
    ctl_we    = 1'b0;
    res_we    = 1'b0;
    cnt_wd    = cnt_rd;
    rld_wd    = rld_rd;
    ctl_wd    = ctl_rd;
    res_wd    = res_rd;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = s_axis_tuser;
          vld_d = s_idx_ok;
          val_d = s_axis_tdata[IDX_W +: DATA_W];
          cyc_d = s_axis_tdata[IDX_W+DATA_W +: CYCLE_BITS];
          rd_d  = '0;
          irq_d = '0;
          if (s_axis_tuser == OP_TICK) begin
            cur_d   = '0;
            state_d = ST_SCAN;
          end else begin
            cur_d   = CW'(s_axis_tdata[IDX_W-1:0]);
            state_d = ST_REG;
          end
        end
      end

      ST_REG: begin
        if (vld_q && cur_ok) begin
          unique case (op_q)
            OP_WR_CTL: begin
              ctl_we = 1'b1;
              ctl_wd = val_q;
              // Turning enable on restarts the prescaler and loads the reload value.
              if (!ctl_rd[CTL_ENABLE_BIT] && val_q[CTL_ENABLE_BIT]) begin
                res_we = 1'b1;
                res_wd = '0;
                cnt_we = 1'b1;
                cnt_wd = rld_rd;
              end
            end
            OP_WR_RELOAD: begin
              rld_we = 1'b1;
              rld_wd = val_q;
              if (!ctl_rd[CTL_ENABLE_BIT]) begin
                cnt_we = 1'b1;
                cnt_wd = val_q;
              end
            end
            OP_RD_CTL:   rd_d = ctl_rd;
            OP_RD_COUNT: rd_d = cnt_rd;
            default: ;
          endcase
        end
        state_d = ST_FIN;
      end

      ST_SCAN: begin
        if (!cur_ok) begin
          state_d = ST_FIN;
        end else if (ctl_rd[CTL_ENABLE_BIT] &&
                     (cur_q == '0 || !ctl_rd[CTL_CASCADE_BIT])) begin
          res_we  = 1'b1;
          res_wd  = RES_W'(total & ((TW'(1) << sh) - TW'(1)));
          n_d     = total >> sh;
          state_d = ST_ADV;
        end else begin
          cur_d = cur_q + CW'(1);
        end
      end

      ST_ADV: begin
        if (CMP_W'(n_q) < CMP_W'(wrap)) begin
          cnt_we  = 1'b1;
          cnt_wd  = cnt_rd + 16'(n_q);
          // Chain ends here; the scan then skips timers that are disabled or cascaded.
          cur_d   = cur_q + CW'(1);
          state_d = ST_SCAN;
        end else begin
          dvd_d   = n_q - TW'(wrap);
          rem_d   = '0;
          per_d   = 17'h10000 - {1'b0, rld_rd};
          bcnt_d  = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, per_q}) begin
          rem_d = 17'(rem_sh - {1'b0, per_q});
          dvd_d = {dvd_q[TW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[16:0];
          dvd_d = {dvd_q[TW-2:0], 1'b0};
        end
        bcnt_d = bcnt_q + BC_W'(1);
        if (bcnt_q == BC_W'(TW - 1)) begin
          state_d = ST_DIVEND;
        end
      end

      ST_DIVEND: begin
        cnt_we = 1'b1;
        cnt_wd = rld_rd + rem_q[DATA_W-1:0];
        if (ctl_rd[CTL_IRQ_BIT]) begin
          for (int i = 0; i < IRQ_W; i++) begin
            if (int'(cur_q) == i) begin
              irq_d[i] = 1'b1;
            end
          end
        end
        n_d     = dvd_q + TW'(1);
        cur_d   = cur_q + CW'(1);
        state_d = ST_CHAIN;
      end

      ST_CHAIN: begin
        if (!cur_ok) begin
          state_d = ST_FIN;
        end else if (ctl_rd[CTL_ENABLE_BIT] && ctl_rd[CTL_CASCADE_BIT]) begin
          state_d = ST_ADV;
        end else begin
          state_d = ST_SCAN;
        end
      end

      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({irq_q, rd_q});
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cnt_q[i] <= '0;
        rld_q[i] <= '0;
        ctl_q[i] <= '0;
        res_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      m_valid_q <= m_valid_d;
      if (cnt_we) begin
        cnt_q[ix] <= cnt_wd;
      end
      if (rld_we) begin
        rld_q[ix] <= rld_wd;
      end
      if (ctl_we) begin
        ctl_q[ix] <= ctl_wd;
      end
      if (res_we) begin
        res_q[ix] <= res_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    vld_q    <= vld_d;
    val_q    <= val_d;
    cyc_q    <= cyc_d;
    rd_q     <= rd_d;
    irq_q    <= irq_d;
    n_q      <= n_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    per_q    <= per_d;
    bcnt_q   <= bcnt_d;
    m_data_q <= m_data_d;
  end

  `CPTB_ASSERT(a_busy_after_accept, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `CPTB_ASSERT(a_rem_below_period, clk_i, rst_ni, (state_q == ST_DIV) |-> (rem_q < per_q))
  `CPTB_NEVER(a_cursor_range, clk_i, rst_ni, cur_q > CW'(NUM_TIMERS))
  `CPTB_ASSERT(a_result_from_finish, clk_i, rst_ni, $rose(m_valid_q) |-> $past(state_q == ST_FIN))

endmodule
